/* rtl/bsc_pkg.sv */
package bsc_pkg;

    localparam int NUM_PROCESSES_DEF = 16;
    localparam int NUM_TYPES         = 3;
    localparam int VAL_W             = 8;
    localparam int WORK_W            = 13;
    localparam int PROC_W            = 4;
    localparam int CFG_IDX_W         = 2;

    localparam logic [WORK_W-1:0] WORK_MAX = 13'h1FFF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_AVAIL_R0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AVAIL_R1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AVAIL_R2 = 2'd2;

    typedef struct packed {
        logic [VAL_W-1:0] alloc_r0;
        logic [VAL_W-1:0] alloc_r1;
        logic [VAL_W-1:0] alloc_r2;
        logic [VAL_W-1:0] max_r0;
        logic [VAL_W-1:0] max_r1;
        logic [VAL_W-1:0] max_r2;
        logic             last_row;
    } t_in_item;

    typedef struct packed {
        logic [PROC_W-1:0] proc_index;
        logic              is_safe;
        logic              last_result;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic init;
        logic take;
        logic ptr_inc;
        logic emit;
        logic emit_unsafe;
        logic finish;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic set_end;
        logic hit;
        logic ptr_last;
        logic round_last;
        logic out_last;
    } t_dp_sts;

endpackage

/* rtl/bsc_dpath.sv */
module bsc_dpath import bsc_pkg::*; #(
    parameter int NUM_PROCESSES = NUM_PROCESSES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [VAL_W-1:0]     i_cfg_data,
    input  t_in_item             i_item,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    output t_out_item            o_result,
    output logic                 o_strobe
);

    localparam int IDX_W = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1;
    localparam int CNT_W = $clog2(NUM_PROCESSES + 1);

    typedef logic [NUM_TYPES-1:0][VAL_W-1:0]  t_lanes;
    typedef logic [NUM_TYPES-1:0][WORK_W-1:0] t_work;

    t_lanes                  alloc_mem [NUM_PROCESSES];
    t_lanes                  need_mem  [NUM_PROCESSES];
    logic [IDX_W-1:0]        seq_mem   [NUM_PROCESSES];

    t_lanes                  r_avail;
    t_lanes                  r_alloc_q;
    t_lanes                  r_need_q;
    logic [IDX_W-1:0]        r_seq_q;
    logic [CNT_W-1:0]        r_cnt;
    logic [CNT_W-1:0]        r_round;
    logic [CNT_W-1:0]        r_ocnt;
    logic [IDX_W-1:0]        r_ptr;
    logic [NUM_PROCESSES-1:0] r_mask;
    t_work                   r_work;
    t_out_item               r_out;
    logic                    r_out_vld;

    t_lanes                  alloc_in;
    t_lanes                  need_in;
    t_lanes                  max_in;
    t_work                   n_work_take;
    logic                    fits;
    logic [WORK_W:0]         sum;
    logic [IDX_W+PROC_W-1:0] seq_ext;

    assign alloc_in = {i_item.alloc_r2, i_item.alloc_r1, i_item.alloc_r0};
    assign max_in   = {i_item.max_r2, i_item.max_r1, i_item.max_r0};
    assign seq_ext  = {{PROC_W{1'b0}}, r_seq_q};

    always_comb begin
        fits = 1'b1;
        sum  = '0;
        for (int t = 0; t < NUM_TYPES; t++) begin
            // negative need held at zero
            need_in[t] = (max_in[t] > alloc_in[t]) ? (max_in[t] - alloc_in[t]) : '0;
            if (WORK_W'(r_need_q[t]) > r_work[t]) begin
                fits = 1'b0;
            end
            sum = {1'b0, r_work[t]} + (WORK_W+1)'(r_alloc_q[t]);
            n_work_take[t] = sum[WORK_W] ? WORK_MAX : sum[WORK_W-1:0];
        end
    end

    assign o_sts.set_end    = i_item.last_row || (r_cnt + CNT_W'(1) == CNT_W'(NUM_PROCESSES));
    assign o_sts.hit        = !r_mask[r_ptr] && fits;
    assign o_sts.ptr_last   = (CNT_W'(r_ptr) + CNT_W'(1) == r_cnt);
    assign o_sts.round_last = (r_round + CNT_W'(1) == r_cnt);
    assign o_sts.out_last   = (r_ocnt + CNT_W'(1) == r_cnt);

    // row stores and sequence store
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            alloc_mem[r_cnt[IDX_W-1:0]] <= alloc_in;
            need_mem[r_cnt[IDX_W-1:0]]  <= need_in;
        end
        if (i_cmd.take) begin
            seq_mem[r_round[IDX_W-1:0]] <= r_ptr;
        end
        r_alloc_q <= alloc_mem[r_ptr];
        r_need_q  <= need_mem[r_ptr];
        r_seq_q   <= seq_mem[r_ocnt[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avail   <= '0;
            r_cnt     <= '0;
            r_round   <= '0;
            r_ocnt    <= '0;
            r_ptr     <= '0;
            r_mask    <= '0;
            r_work    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_AVAIL_R0: r_avail[0] <= i_cfg_data;
                    CFG_AVAIL_R1: r_avail[1] <= i_cfg_data;
                    CFG_AVAIL_R2: r_avail[2] <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (i_cmd.init) begin
                for (int t = 0; t < NUM_TYPES; t++) begin
                    r_work[t] <= WORK_W'(r_avail[t]);
                end
                r_mask  <= '0;
                r_ptr   <= '0;
                r_round <= '0;
                r_ocnt  <= '0;
            end
            if (i_cmd.take) begin
                r_work         <= n_work_take;
                r_mask[r_ptr]  <= 1'b1;
                r_round        <= r_round + CNT_W'(1);
                r_ptr          <= '0;
            end
            if (i_cmd.ptr_inc) begin
                r_ptr <= r_ptr + IDX_W'(1);
            end
            if (i_cmd.emit) begin
                r_out.proc_index  <= seq_ext[PROC_W-1:0];
                r_out.is_safe     <= 1'b1;
                r_out.last_result <= o_sts.out_last;
                r_out_vld         <= 1'b1;
                r_ocnt            <= r_ocnt + CNT_W'(1);
            end
            if (i_cmd.emit_unsafe) begin
                r_out.proc_index  <= '0;
                r_out.is_safe     <= 1'b0;
                r_out.last_result <= 1'b1;
                r_out_vld         <= 1'b1;
            end
            if (i_cmd.finish) begin
                r_cnt <= '0;
            end
        end
    end

    assign o_result = r_out;
    assign o_strobe = r_out_vld;

endmodule

/* rtl/bsc_ctrl.sv */
module bsc_ctrl import bsc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    o_busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CHK,
        S_ORD,
        S_OEMIT,
        S_UNSAFE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_sts.set_end) begin
                        o_cmd.init = 1'b1;
                        n_state    = S_RD;
                    end
                end
            end
            S_RD: n_state = S_CHK;
            S_CHK: begin
                if (i_sts.hit) begin
                    o_cmd.take = 1'b1;
                    n_state    = i_sts.round_last ? S_ORD : S_RD;
                end else if (i_sts.ptr_last) begin
                    n_state = S_UNSAFE;
                end else begin
                    o_cmd.ptr_inc = 1'b1;
                    n_state       = S_RD;
                end
            end
            S_ORD: n_state = S_OEMIT;
            S_OEMIT: begin
                o_cmd.emit = 1'b1;
                if (i_sts.out_last) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_ORD;
                end
            end
            S_UNSAFE: begin
                o_cmd.emit_unsafe = 1'b1;
                o_cmd.finish      = 1'b1;
                n_state           = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign o_busy = r_busy;

endmodule

/* rtl/bankers_safety_check.sv */
// channel   direction  handshake                    payload
// input     in         start high, busy low         i_item (t_in_item)
// result    out        o_strobe, one cycle, no hold o_result (t_out_item)
// config    in         i_cfg_we                     i_cfg_idx, i_cfg_data
//
// a row that does not close the set is only stored; busy stays low
// the check reads each row examined in S_RD (one memory read port on the row
// stores) and tests it in S_CHK, up to N rounds of up to N rows
// a safe set reports items via S_ORD and S_OEMIT, an unsafe one a single item
// synchronous active-low reset; no clearing pass, the row stores need none
// the receiver cannot stall: each result is shown for exactly one cycle
module bankers_safety_check import bsc_pkg::*; #(
    parameter int NUM_PROCESSES = NUM_PROCESSES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_in_item             i_item,
    output logic                 o_strobe,
    output t_out_item            o_result,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [VAL_W-1:0]     i_cfg_data
);

    // command and status between controller and datapath
    t_dp_cmd cmd;
    t_dp_sts sts;

    // controller: row loading, scan sequencing, result emission
    bsc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // datapath: row stores, work lanes, finished mask, sequence store
    bsc_dpath #(
        .NUM_PROCESSES (NUM_PROCESSES)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_item),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_result   (o_result),
        .o_strobe   (o_strobe)
    );

    // a row that neither ends nor fills the set keeps the block free
    a_row_keeps_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !sts.set_end) |=> !busy)
        else $error("block went busy on a row that does not close the set");

    // loading never overlaps the check or result emission
    a_load_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |-> !(cmd.take || cmd.emit || cmd.emit_unsafe || cmd.ptr_inc))
        else $error("row load overlaps check activity");

    // an unsafe verdict is a lone final item with a zero index
    a_unsafe_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.is_safe) |-> (o_result.last_result && o_result.proc_index == '0))
        else $error("malformed unsafe verdict");

    // every result comes from a check that held the block busy
    a_result_from_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result without a preceding check");

endmodule

/* test/bankers_safety_check_test.sv */
module bankers_safety_check_test;

    timeunit 1ns;
    timeprecision 1ps;

    import bsc_pkg::*;

    localparam int HALF_PERIOD = 4;
    localparam int RESET_CYCLES = 5;
    localparam int LIMIT_NS = 4_000_000;
    // about 380 rows in all: the directed part plus the random part
    localparam int RANDOM_ROWS = 360;
    localparam int PHASE_ROWS = 40;
    // extra cycles waited once the block is idle and every expected result is in
    localparam int SETTLE_CYCLES = 8;
    localparam int REPORT_LIMIT = 10;
    // index with no register behind it; writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] AVAIL_IDX [NUM_TYPES] =
        '{CFG_AVAIL_R0, CFG_AVAIL_R1, CFG_AVAIL_R2};
    localparam logic [VAL_W-1:0] VAL_MAX = 8'hFF;

    // predicts the safe sequence (or the unsafe verdict) of each set and
    // compares the reported entries against it
    class safety_scoreboard;
        logic [VAL_W-1:0] avail [NUM_TYPES];
        logic [VAL_W-1:0] alloc_rows [NUM_PROCESSES_DEF][NUM_TYPES];
        logic [VAL_W-1:0] need_rows [NUM_PROCESSES_DEF][NUM_TYPES];
        int rows_held;
        t_out_item sequence_q[$];
        int mismatches;

        function new();
            foreach (avail[t]) avail[t] = '0;
            rows_held = 0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] data);
            case (idx)
                CFG_AVAIL_R0: avail[0] = data;
                CFG_AVAIL_R1: avail[1] = data;
                CFG_AVAIL_R2: avail[2] = data;
                default: ;
            endcase
        endfunction

        function void note_row(t_in_item row);
            logic [VAL_W-1:0] a [NUM_TYPES];
            logic [VAL_W-1:0] m [NUM_TYPES];
            logic [WORK_W-1:0] work [NUM_TYPES];
            logic [WORK_W:0] sum;
            logic [NUM_PROCESSES_DEF-1:0] done_mask;
            int order[$];
            bit found, fits;
            t_out_item e;
            a = '{row.alloc_r0, row.alloc_r1, row.alloc_r2};
            m = '{row.max_r0, row.max_r1, row.max_r2};
            if (rows_held < NUM_PROCESSES_DEF) begin
                for (int t = 0; t < NUM_TYPES; t++) begin
                    alloc_rows[rows_held][t] = a[t];
                    need_rows[rows_held][t] = (m[t] > a[t]) ? m[t] - a[t] : '0;
                end
                rows_held++;
            end
            if (!row.last_row && rows_held < NUM_PROCESSES_DEF)
                return;
            // greedy search: lowest unfinished process that fits, each round
            for (int t = 0; t < NUM_TYPES; t++)
                work[t] = WORK_W'(avail[t]);
            done_mask = '0;
            found = 1'b1;
            for (int r = 0; r < rows_held && found; r++) begin
                found = 1'b0;
                for (int p = 0; p < rows_held && !found; p++) begin
                    fits = !done_mask[p];
                    for (int t = 0; t < NUM_TYPES; t++)
                        if (WORK_W'(need_rows[p][t]) > work[t]) fits = 1'b0;
                    if (fits) begin
                        for (int t = 0; t < NUM_TYPES; t++) begin
                            sum = {1'b0, work[t]} + alloc_rows[p][t];
                            work[t] = (sum > WORK_MAX) ? WORK_MAX : sum[WORK_W-1:0];
                        end
                        done_mask[p] = 1'b1;
                        order = {order, p};
                        found = 1'b1;
                    end
                end
            end
            if (order.size() == rows_held) begin
                foreach (order[r]) begin
                    e.proc_index = PROC_W'(order[r]);
                    e.is_safe = 1'b1;
                    e.last_result = (r == rows_held - 1);
                    sequence_q = {sequence_q, e};
                end
            end else begin
                e.proc_index = '0;
                e.is_safe = 1'b0;
                e.last_result = 1'b1;
                sequence_q = {sequence_q, e};
            end
            rows_held = 0;
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (sequence_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result: proc %0d safe %b last %b",
                             got.proc_index, got.is_safe, got.last_result);
                return;
            end
            want = sequence_q.pop_front();
            if (got.proc_index !== want.proc_index || got.is_safe !== want.is_safe ||
                    got.last_result !== want.last_result) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("expected proc %0d safe %b last %b, got proc %0d safe %b last %b",
                             want.proc_index, want.is_safe, want.last_result,
                             got.proc_index, got.is_safe, got.last_result);
            end
        endfunction

        function int pending();
            return sequence_q.size();
        endfunction

        function int fault_count();
            if (sequence_q.size() != 0)
                $display("%0d expected results never arrived", sequence_q.size());
            return mismatches + sequence_q.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_in_item i_item = '0;
    logic o_strobe;
    t_out_item o_result;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [VAL_W-1:0] i_cfg_data = '0;

    safety_scoreboard sb = new();
    int rows_sent = 0;

    bankers_safety_check #(
        .NUM_PROCESSES(NUM_PROCESSES_DEF)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_item    (i_item),
        .o_strobe  (o_strobe),
        .o_result  (o_result),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // watch all three channels on the sampled (pre-edge) values
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we)
                sb.write_reg(i_cfg_idx, i_cfg_data);
            if (start && !busy)
                sb.note_row(i_item);
            if (o_strobe)
                sb.check_result(o_result);
        end
    end

    // one register write per cycle; caller lowers the enable afterwards
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // present one row and hold it until the block takes it; start stays high
    // afterwards so back-to-back rows need no second assignment in a step
    task automatic send_row(input t_in_item row);
        bit gaps_on;
        // long stretch in the middle with no idling at all
        gaps_on = (rows_sent < 150 || rows_sent >= 250);
        if (gaps_on && $urandom_range(0, 99) < 10) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_item <= row;
        do @(posedge i_clk); while (busy);
        rows_sent++;
    endtask

    // drop start and wait for the last result of the set, then a little more
    task automatic settle();
        start <= 1'b0;
        // wait for an edge first so the row taken at the previous edge is noted
        @(posedge i_clk);
        while (busy || sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // fresh availability per phase, extremes weighted in
    task automatic new_avail();
        int pick;
        logic [VAL_W-1:0] v;
        for (int t = 0; t < NUM_TYPES; t++) begin
            pick = $urandom_range(0, 3);
            case (pick)
                0: v = '0;
                1: v = VAL_MAX;
                2: v = VAL_W'($urandom_range(0, 20));
                default: v = VAL_W'($urandom_range(0, 255));
            endcase
            write_reg(AVAIL_IDX[t], v);
        end
        if ($urandom_range(0, 4) == 0)
            write_reg(CFG_UNUSED, VAL_W'($urandom_range(0, 255)));
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_in_item pack_row(logic [VAL_W-1:0] a [NUM_TYPES],
                                          logic [VAL_W-1:0] m [NUM_TYPES], bit last);
        t_in_item row;
        row.alloc_r0 = a[0];
        row.alloc_r1 = a[1];
        row.alloc_r2 = a[2];
        row.max_r0 = m[0];
        row.max_r1 = m[1];
        row.max_r2 = m[2];
        row.last_row = last;
        return row;
    endfunction

    // a set of rows: mostly built around a hidden safe order so the check
    // gets deep, some with a little slack in the needs, some fully random
    function automatic void build_set(input int size, output t_in_item rows[$]);
        int slot [NUM_PROCESSES_DEF];
        int work [NUM_TYPES];
        logic [VAL_W-1:0] a [NUM_TYPES];
        logic [VAL_W-1:0] m [NUM_TYPES];
        t_in_item staged [NUM_PROCESSES_DEF];
        int kind, j, tmp, roof;
        bit last;
        kind = $urandom_range(0, 99);
        for (int i = 0; i < size; i++) slot[i] = i;
        for (int i = size - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = slot[i];
            slot[i] = slot[j];
            slot[j] = tmp;
        end
        for (int t = 0; t < NUM_TYPES; t++) work[t] = int'(sb.avail[t]);
        for (int k = 0; k < size; k++) begin
            for (int t = 0; t < NUM_TYPES; t++) begin
                a[t] = ($urandom_range(0, 3) == 0) ? VAL_W'($urandom_range(0, 255))
                                                   : VAL_W'($urandom_range(0, 12));
                roof = 255 - int'(a[t]);
                if (kind < 60) begin
                    // need fits the work built up along the hidden order
                    if (work[t] < roof) roof = work[t];
                    m[t] = a[t] + VAL_W'($urandom_range(0, roof));
                end else if (kind < 80) begin
                    // a few units of slack: may or may not deadlock
                    if (work[t] + 6 < roof) roof = work[t] + 6;
                    m[t] = a[t] + VAL_W'($urandom_range(0, roof));
                end else begin
                    m[t] = VAL_W'($urandom_range(0, 255));
                end
                // claim below the allocation now and then
                if ($urandom_range(0, 9) == 0)
                    m[t] = VAL_W'($urandom_range(0, a[t]));
                work[t] += int'(a[t]);
            end
            staged[slot[k]] = pack_row(a, m, 1'b0);
        end
        rows = {};
        for (int i = 0; i < size; i++) begin
            // a full set closes itself, so its flag may go either way
            last = (i == size - 1) && (size < NUM_PROCESSES_DEF || $urandom_range(0, 1));
            staged[i].last_row = last;
            rows = {rows, staged[i]};
        end
    endfunction

    initial begin
        logic [VAL_W-1:0] a [NUM_TYPES];
        logic [VAL_W-1:0] m [NUM_TYPES];
        t_in_item set_rows[$];
        int phase_rows, size, pick;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, nothing available
        for (int t = 0; t < NUM_TYPES; t++) write_reg(AVAIL_IDX[t], '0);
        write_reg(CFG_UNUSED, VAL_MAX);
        i_cfg_we <= 1'b0;

        // single idle process: safe at once
        a = '{default: '0};
        m = '{default: '0};
        send_row(pack_row(a, m, 1'b1));
        // full claim with nothing available: unsafe verdict
        m = '{default: VAL_MAX};
        send_row(pack_row(a, m, 1'b1));
        // claim below allocation: need held at zero
        a = '{default: VAL_MAX};
        m = '{default: '0};
        send_row(pack_row(a, m, 1'b1));
        // store filled without a last flag; needs fall with the row number,
        // so the safe order runs from the top row down
        for (int p = 0; p < NUM_PROCESSES_DEF; p++) begin
            a = '{default: 8'd1};
            m = '{default: VAL_W'(1 + NUM_PROCESSES_DEF - 1 - p)};
            send_row(pack_row(a, m, 1'b0));
        end
        settle();

        // everything available: a need equal to the work still fits
        for (int t = 0; t < NUM_TYPES; t++) write_reg(AVAIL_IDX[t], VAL_MAX);
        i_cfg_we <= 1'b0;
        a = '{default: '0};
        m = '{default: VAL_MAX};
        send_row(pack_row(a, m, 1'b1));
        settle();

        // random part in phases, each with its own availability
        new_avail();
        phase_rows = 0;
        while (rows_sent < RANDOM_ROWS + 20) begin
            if (phase_rows >= PHASE_ROWS) begin
                settle();
                new_avail();
                phase_rows = 0;
            end
            pick = $urandom_range(0, 99);
            if (pick < 70)
                size = $urandom_range(1, 6);
            else if (pick < 90)
                size = $urandom_range(7, NUM_PROCESSES_DEF - 1);
            else
                size = NUM_PROCESSES_DEF;
            build_set(size, set_rows);
            foreach (set_rows[i]) send_row(set_rows[i]);
            phase_rows += size;
        end
        settle();

        if (sb.fault_count() == 0)
            $display("bankers_safety_check_test: clean");
        else
            $display("bankers_safety_check_test: errors");
        $finish;
    end

    // hard stop well past the slowest correct run
    initial begin
        #(LIMIT_NS);
        $display("bankers_safety_check_test: errors");
        $finish;
    end

endmodule
